>>> src/nhcs_pkg.sv
// ----------------------------------------------------------------------------
// nhcs_pkg
// Shared constants and types for the neo-Hookean Cauchy stress pipeline.
// ----------------------------------------------------------------------------
package nhcs_pkg;

   // fraction bits of the moduli (Q16.16)
   localparam int MOD_FRAC  = 16;
   localparam int N_GRAD    = 9;
   localparam int N_STRESS  = 6;
   localparam int N_PROD    = 24;
   localparam int CSR_IDX_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_SHEAR_MODULUS     = 2'd0;
   localparam csr_idx_type REG_BULK_MODULUS      = 2'd1;
   localparam csr_idx_type REG_PLANE_STRAIN_MODE = 2'd2;

   typedef logic [3:0] grad_sel_type;

   // operand pairs of the first product stage, row-major gradient index
   // 0..5  : cofactor products f22f33, f23f32, f21f33, f23f31, f21f32, f22f31
   // 6..23 : rows of b in Voigt order 11, 22, 33, 23, 13, 12, three each
   localparam grad_sel_type PROD_A [N_PROD] = '{
      4'd4, 4'd5, 4'd3, 4'd5, 4'd3, 4'd4,
      4'd0, 4'd1, 4'd2,  4'd3, 4'd4, 4'd5,  4'd6, 4'd7, 4'd8,
      4'd3, 4'd4, 4'd5,  4'd0, 4'd1, 4'd2,  4'd0, 4'd1, 4'd2};
   localparam grad_sel_type PROD_B [N_PROD] = '{
      4'd8, 4'd7, 4'd8, 4'd6, 4'd7, 4'd6,
      4'd0, 4'd1, 4'd2,  4'd3, 4'd4, 4'd5,  4'd6, 4'd7, 4'd8,
      4'd6, 4'd7, 4'd8,  4'd6, 4'd7, 4'd8,  4'd3, 4'd4, 4'd5};

endpackage

>>> src/neo_hookean_cauchy_stress.sv
// ----------------------------------------------------------------------------
// neo_hookean_cauchy_stress
// Pipelined compressible neo-Hookean Cauchy stress from a deformation gradient.
// ----------------------------------------------------------------------------
//
// channel | dir | handshake            | word
// --------+-----+----------------------+---------------------------------------
// req_    | in  | req_tvalid/tready    | tdata f11..f33, tlast last_in_batch
// rsp_    | out | rsp_tvalid/tready    | tdata s11..s12, tuser bad_jacobian,
//         |     |                      | tlast last_out
// csr_    | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One word per cycle while the skid entry is empty. Eleven front stages
// (products, cofactors, J, split wide multiplies, numerator, rounding
// offset) lead to one restoring-division stage per quotient bit, then to
// the output register. Reset clears the valid bits and the configuration
// registers. The whole pipeline advances together; a two-entry output
// (register plus skid) keeps taking words while a result waits, and
// req_tready drops only once the skid entry is full.
//
module neo_hookean_cauchy_stress #(
   parameter int GRAD_WIDTH   = 32,
   parameter int STRESS_WIDTH = 48
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // f11,f12,f13,f21,f22,f23,f31,f32,f33 from bit 0 up, zero padded
   input  logic [((9*GRAD_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // s11,s22,s33,s23,s13,s12 from bit 0 up, zero padded
   output logic [((6*STRESS_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // bad_jacobian
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  nhcs_pkg::csr_idx_type                  csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int G    = GRAD_WIDTH;
   localparam int S    = STRESS_WIDTH;
   localparam int GF   = G - 4;
   localparam int SF   = S / 2;
   localparam int MF   = nhcs_pkg::MOD_FRAC;
   localparam int KSH  = (SF >= MF) ? SF - MF : 0;
   localparam int DSH  = (SF >= MF) ? 0 : MF - SF;
   localparam int NS   = nhcs_pkg::N_STRESS;
   localparam int PW   = 2*G;
   localparam int CW   = 2*G + 1;
   localparam int BW   = 2*G + 2;
   localparam int BBW  = BW + 1;
   localparam int PJW  = 2*G + 1;
   localparam int JW   = 3*G + 3;
   localparam int JMW  = JW + 1;
   localparam int PMLW = 33 + G + 1;
   localparam int PMHW = 33 + BBW - G;
   localparam int MBW  = 33 + BBW;
   localparam int PKLW = 33 + G + 1;
   localparam int PKHW = 33 + JMW - 2*G;
   localparam int KJW  = 33 + JMW;
   localparam int NW   = 3*G + 38 + KSH;
   localparam int NAW  = NW + 2;
   localparam int DW   = JW - 1 + DSH;
   localparam int D2W  = DW + 1;
   localparam int HW   = NAW - S;
   localparam int NP   = 11 + S;
   localparam int XW   = (HW > D2W) ? HW : D2W;

   localparam logic signed [BBW-1:0] ONE2 =
      $signed({{(BBW-2*GF-1){1'b0}}, 1'b1, {(2*GF){1'b0}}});
   localparam logic signed [JMW-1:0] ONE3 =
      $signed({{(JMW-3*GF-1){1'b0}}, 1'b1, {(3*GF){1'b0}}});
   localparam logic [S-1:0] POS_LIM = {1'b0, {(S-1){1'b1}}};
   localparam logic [S-1:0] NEG_LIM = {1'b1, {(S-1){1'b0}}};

   // configuration
   logic [31:0] mu_ff, kappa_ff;
   logic        plane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= '0;
         kappa_ff <= '0;
         plane_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            nhcs_pkg::REG_SHEAR_MODULUS:     mu_ff    <= csr_data;
            nhcs_pkg::REG_BULK_MODULUS:      kappa_ff <= csr_data;
            nhcs_pkg::REG_PLANE_STRAIN_MODE: plane_ff <= csr_data[0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // pipeline control: valid, batch marker and bad-J flag ride along
   logic          en;
   logic [NP-1:0] vld_ff, lst_ff, bad_ff;
   logic          bad_in;
   logic          sk_vld_ff, o_vld_ff;

   assign en         = !sk_vld_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NP-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lst_ff <= {lst_ff[NP-2:0], req_tlast};
         bad_ff <= {bad_ff[NP-2:5], bad_in, 5'b0};
      end
   end

   // stage 0: gradient capture, plane strain substitution
   logic signed [G-1:0] f_in [9];
   logic signed [G-1:0] f_ff [9];

   always_comb begin
      for (int i = 0; i < 9; i++) f_in[i] = $signed(req_tdata[i*G +: G]);
      if (plane_ff) begin
         f_in[2] = '0;
         f_in[5] = '0;
         f_in[6] = '0;
         f_in[7] = '0;
         f_in[8] = $signed({4'b0001, {GF{1'b0}}});
      end
   end

   // stage 1: 24 component products
   logic signed [PW-1:0] pr_in [nhcs_pkg::N_PROD];
   logic signed [PW-1:0] pr_ff [nhcs_pkg::N_PROD];
   logic signed [G-1:0]  fa1_ff [3];
   logic signed [G-1:0]  fa2_ff [3];

   always_comb begin
      for (int k = 0; k < nhcs_pkg::N_PROD; k++)
         pr_in[k] = f_ff[nhcs_pkg::PROD_A[k]] * f_ff[nhcs_pkg::PROD_B[k]];
   end

   // stage 2: cofactors of the first row and b = F*F^T
   logic signed [CW-1:0] cof_in [3];
   logic signed [CW-1:0] cof_ff [3];
   logic signed [BW-1:0] b_in [NS];
   logic signed [BW-1:0] b_ff [NS];

   always_comb begin
      for (int i = 0; i < 3; i++)
         cof_in[i] = CW'(pr_ff[2*i]) - CW'(pr_ff[2*i+1]);
      for (int i = 0; i < NS; i++)
         b_in[i] = BW'(pr_ff[6+3*i]) + BW'(pr_ff[7+3*i]) + BW'(pr_ff[8+3*i]);
   end

   // stage 3: f1k * cofactor as two partials; b - I on the diagonal
   logic signed [PJW-1:0] pjl_in [3], pjh_in [3];
   logic signed [PJW-1:0] pjl_ff [3], pjh_ff [3];
   logic signed [BBW-1:0] bb_in [NS];
   logic signed [BBW-1:0] bb_ff [NS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pjl_in[i] = fa2_ff[i] * $signed({1'b0, cof_ff[i][G-1:0]});
         pjh_in[i] = fa2_ff[i] * $signed(cof_ff[i][CW-1:G]);
      end
      for (int i = 0; i < NS; i++) begin
         if (i < 3) bb_in[i] = BBW'(b_ff[i]) - ONE2;
         else       bb_in[i] = BBW'(b_ff[i]);
      end
   end

   // stage 4: J; mu * (b - I) as two partials
   logic signed [JW-1:0]   j_in, j_ff;
   logic signed [JW-1:0]   jt [3];
   logic signed [32:0]     mus, kas;
   logic signed [PMLW-1:0] pml_in [NS], pml_ff [NS];
   logic signed [PMHW-1:0] pmh_in [NS], pmh_ff [NS];

   assign mus = $signed({1'b0, mu_ff});
   assign kas = $signed({1'b0, kappa_ff});

   always_comb begin
      for (int i = 0; i < 3; i++)
         jt[i] = (JW'(pjh_ff[i]) <<< G) + JW'(pjl_ff[i]);
      j_in = jt[0] - jt[1] + jt[2];
      for (int i = 0; i < NS; i++) begin
         pml_in[i] = mus * $signed({1'b0, bb_ff[i][G-1:0]});
         pmh_in[i] = mus * $signed(bb_ff[i][BBW-1:G]);
      end
   end

   // stage 5: J - 1, J <= 0 check, denominator, mu terms summed
   logic signed [JMW-1:0] jm_in, jm_ff;
   logic [DW-1:0]         den_in;
   logic [DW-1:0]         den_ff [4];
   logic signed [MBW-1:0] mb_in [NS];
   logic signed [MBW-1:0] mb_ff [3][NS];

   always_comb begin
      jm_in  = JMW'(j_ff) - ONE3;
      bad_in = j_ff[JW-1] || (j_ff == '0);
      den_in = DW'(j_ff[JW-2:0]) << DSH;
      for (int i = 0; i < NS; i++)
         mb_in[i] = (MBW'(pmh_ff[i]) <<< G) + MBW'(pml_ff[i]);
   end

   // stage 6: kappa * (J - 1) as three partials
   logic signed [PKLW-1:0] pkl_in, pkm_in, pkl_ff, pkm_ff;
   logic signed [PKHW-1:0] pkh_in, pkh_ff;

   always_comb begin
      pkl_in = kas * $signed({1'b0, jm_ff[G-1:0]});
      pkm_in = kas * $signed({1'b0, jm_ff[2*G-1:G]});
      pkh_in = kas * $signed(jm_ff[JMW-1:2*G]);
   end

   // stage 7: volumetric term
   logic signed [KJW-1:0] kj_in, kj_ff;

   assign kj_in = (KJW'(pkh_ff) <<< (2*G)) + (KJW'(pkm_ff) <<< G) + KJW'(pkl_ff);

   // stage 8: numerators scaled to the output fraction
   logic signed [NW-1:0] num_in [NS], num_ff [NS];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (i < 3) num_in[i] = ((NW'(mb_ff[2][i]) <<< GF) + NW'(kj_ff)) <<< KSH;
         else       num_in[i] = (NW'(mb_ff[2][i]) <<< GF) <<< KSH;
      end
   end

   // stage 9: 2|n| + d over 2d gives round half away from zero
   logic [NW-1:0]  mag [NS];
   logic [NAW-1:0] n2_in [NS], n2_ff [NS];
   logic [NS-1:0]  neg_in, neg_ff;
   logic [D2W-1:0] d2_in, d2_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         neg_in[i] = num_ff[i][NW-1];
         mag[i]    = num_ff[i][NW-1] ? NW'(-num_ff[i]) : NW'(num_ff[i]);
         n2_in[i]  = (NAW'(mag[i]) << 1) + NAW'(den_ff[3]);
      end
      d2_in = {den_ff[3], 1'b0};
   end

   // stage 10 feeds division slot 0; slots 1..S are one quotient bit each
   logic [D2W-1:0] rem_ff [S+1][NS];
   logic [S-1:0]   nq_ff  [S+1][NS];
   logic [NS-1:0]  ov_ff  [S+1];
   logic [NS-1:0]  dng_ff [S+1];
   logic [D2W-1:0] dd_ff  [S+1];
   logic [HW-1:0]  hi [NS];
   logic [NS-1:0]  ov_in;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         hi[i]    = n2_ff[i][NAW-1:S];
         ov_in[i] = XW'(hi[i]) >= XW'(d2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff   <= f_in;
         pr_ff  <= pr_in;
         fa1_ff <= f_ff[0:2];
         fa2_ff <= fa1_ff;
         cof_ff <= cof_in;
         b_ff   <= b_in;
         pjl_ff <= pjl_in;
         pjh_ff <= pjh_in;
         bb_ff  <= bb_in;
         j_ff   <= j_in;
         pml_ff <= pml_in;
         pmh_ff <= pmh_in;
         jm_ff  <= jm_in;
         den_ff <= '{den_in, den_ff[0], den_ff[1], den_ff[2]};
         mb_ff  <= '{mb_in, mb_ff[0], mb_ff[1]};
         pkl_ff <= pkl_in;
         pkm_ff <= pkm_in;
         pkh_ff <= pkh_in;
         kj_ff  <= kj_in;
         num_ff <= num_in;
         n2_ff  <= n2_in;
         neg_ff <= neg_in;
         d2_ff  <= d2_in;
         for (int i = 0; i < NS; i++) begin
            rem_ff[0][i] <= D2W'(hi[i]);
            nq_ff[0][i]  <= n2_ff[i][S-1:0];
         end
         ov_ff[0]  <= ov_in;
         dng_ff[0] <= neg_ff;
         dd_ff[0]  <= d2_ff;
      end
   end

   // restoring division, one quotient bit per stage; quotient shifts in
   // behind the dividend bits that are still to come
   for (genvar d = 0; d < S; d++) begin : g_div
      logic [D2W:0]   t [NS];
      logic [NS-1:0]  ge;
      logic [D2W-1:0] rem_in [NS];

      always_comb begin
         for (int i = 0; i < NS; i++) begin
            t[i]      = {rem_ff[d][i], nq_ff[d][i][S-1]};
            ge[i]     = t[i] >= {1'b0, dd_ff[d]};
            rem_in[i] = ge[i] ? D2W'(t[i] - {1'b0, dd_ff[d]}) : t[i][D2W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < NS; i++) begin
               rem_ff[d+1][i] <= rem_in[i];
               nq_ff[d+1][i]  <= {nq_ff[d][i][S-2:0], ge[i]};
            end
            ov_ff[d+1]  <= ov_ff[d];
            dng_ff[d+1] <= dng_ff[d];
            dd_ff[d+1]  <= dd_ff[d];
         end
      end
   end

   // result: saturate, apply sign, zero on bad J and unused plane terms
   logic [S-1:0] res_in [NS];
   logic [S-1:0] lim [NS];
   logic [S-1:0] qm [NS];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         lim[i] = dng_ff[S][i] ? NEG_LIM : POS_LIM;
         qm[i]  = (ov_ff[S][i] || (nq_ff[S][i] > lim[i])) ? lim[i] : nq_ff[S][i];
         res_in[i] = dng_ff[S][i] ? S'(-qm[i]) : qm[i];
         if (bad_ff[NP-1] || (plane_ff && (i == 2 || i == 3 || i == 4)))
            res_in[i] = '0;
      end
   end

   // output register and skid entry
   logic [S-1:0] o_s_ff [NS], sk_s_ff [NS];
   logic         o_lst_ff, o_bad_ff, sk_lst_ff, sk_bad_ff;
   logic         o_take;

   assign o_take = rsp_tready || !o_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff  <= 1'b0;
         sk_vld_ff <= 1'b0;
      end else if (o_take) begin
         o_vld_ff  <= sk_vld_ff || vld_ff[NP-1];
         sk_vld_ff <= 1'b0;
      end else if (vld_ff[NP-1] && en) begin
         sk_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (o_take) begin
         if (sk_vld_ff) begin
            o_s_ff   <= sk_s_ff;
            o_lst_ff <= sk_lst_ff;
            o_bad_ff <= sk_bad_ff;
         end else begin
            o_s_ff   <= res_in;
            o_lst_ff <= lst_ff[NP-1];
            o_bad_ff <= bad_ff[NP-1];
         end
      end else if (en) begin
         sk_s_ff   <= res_in;
         sk_lst_ff <= lst_ff[NP-1];
         sk_bad_ff <= bad_ff[NP-1];
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NS; i++) rsp_tdata[i*S +: S] = o_s_ff[i];
   end
   assign rsp_tvalid = o_vld_ff;
   assign rsp_tlast  = o_lst_ff;
   assign rsp_tuser  = o_bad_ff;

   // checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[6*S-1:0] == '0)
      else $error("bad Jacobian word carries non-zero stress");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_vld_ff |-> o_vld_ff)
      else $error("skid entry held while output register empty");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[11] && !ov_ff[1][0] |-> rem_ff[1][0] < dd_ff[1])
      else $error("division remainder not below divisor");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word straight after reset");

endmodule
